### design/sbvc_pkg.sv
`default_nettype none

package sbvc_pkg;

    // Field widths.
    localparam int COORD_W    = 32;
    localparam int RADIUS_W   = 31;
    localparam int ID_W       = 12;
    localparam int OP_W       = 2;
    localparam int VERDICT_W  = 2;
    localparam int COUNT_W    = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Arithmetic widths: squared axis distance, sum of three squares, radius squared.
    localparam int SQ_W  = 2 * COORD_W;
    localparam int SUM_W = SQ_W + 2;
    localparam int R2_W  = 2 * RADIUS_W;

    // Defaults for the top-level parameters.
    localparam int MAX_OBJECTS_DEF = 4096;
    localparam int WORD_BITS_DEF   = 64;
    localparam int ID_SPACE        = 1 << ID_W;

    // Input beat layout.
    localparam int IN_ID_LSB     = 0;
    localparam int IN_MODEL_BIT  = IN_ID_LSB + ID_W;
    localparam int IN_SHADOW_BIT = IN_MODEL_BIT + 1;
    localparam int IN_LOD_BIT    = IN_SHADOW_BIT + 1;
    localparam int IN_BOX_LSB    = IN_LOD_BIT + 1;
    localparam int IN_USED_W     = IN_BOX_LSB + 6 * COORD_W;
    localparam int IN_TDATA_W    = ((IN_USED_W + 7) / 8) * 8;

    // Output beat layout.
    localparam int OUT_VERDICT_LSB = 0;
    localparam int OUT_QUERY_BIT   = OUT_VERDICT_LSB + VERDICT_W;
    localparam int OUT_VIS_LSB     = OUT_QUERY_BIT + 1;
    localparam int OUT_CUL_LSB     = OUT_VIS_LSB + COUNT_W;
    localparam int OUT_USED_W      = OUT_CUL_LSB + COUNT_W;
    localparam int OUT_TDATA_W     = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W       = OUT_TDATA_W - OUT_USED_W;

    // Pipeline stage numbering.
    localparam int STG_A = 0;  // input register
    localparam int STG_B = 1;  // clamp
    localparam int STG_C = 2;  // axis distance
    localparam int STG_D = 3;  // square
    localparam int STG_E = 4;  // sum, bitset read issued on leaving
    localparam int STG_F = 5;  // compare result and bitset word
    localparam int STG_O = 6;  // output register
    localparam int N_STG = 7;

    typedef enum logic [OP_W-1:0] {
        OP_BEGIN = 2'd0,
        OP_TEST  = 2'd1,
        OP_QUERY = 2'd2
    } t_op;

    typedef enum logic [VERDICT_W-1:0] {
        V_SKIP     = 2'd0,
        V_VISIBLE  = 2'd1,
        V_CULL_LOD = 2'd2,
        V_CULL_OUT = 2'd3
    } t_verdict;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X    = 3'd0,
        CFG_CENTER_Y    = 3'd1,
        CFG_CENTER_Z    = 3'd2,
        CFG_RADIUS      = 3'd3,
        CFG_SHADOW_ONLY = 3'd4
    } t_cfg_reg;

    // Per-item sideband carried alongside the geometry pipeline.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [ID_W-1:0] id;
        logic            has_model;
        logic            casts_shadow;
        logic            has_lod;
    } t_side;

    // Load enables of the three registered steps of one axis.
    typedef struct packed {
        logic b;
        logic c;
        logic d;
    } t_axis_ld;

endpackage

`default_nettype wire

### design/sphere_box_visibility_cull_unit.sv
// An accepted input beat passes stage registers A to F and then O before its result is offered.
// Throughput: one item per cycle, sustained while m_axis_tready stays high, in every mix of operations.
// Reset: synchronous, active low; clears configuration, both counters, the pipeline and
// the valid bits of the visibility bitset at once, so no clearing pass follows reset.
// Rate is set by the single read-modify-write on the bitset memory per item.
`default_nettype none

module sphere_box_visibility_cull_unit #(
    parameter int MAX_OBJECTS = sbvc_pkg::MAX_OBJECTS_DEF,
    parameter int WORD_BITS   = sbvc_pkg::WORD_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration write port.
    input  wire logic                              i_cfg_we,
    input  wire logic [sbvc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [sbvc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Item input.
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata from bit 0: object_id, has_model, casts_shadow, has_lod, box_min_x,
    // box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, zero pad.
    input  wire logic [sbvc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // tuser: op.
    input  wire logic [sbvc_pkg::OP_W-1:0]         s_axis_tuser,
    // Result output.
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // tdata from bit 0: verdict, query_visible, visible_count, culled_count, zero pad.
    output logic [sbvc_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);
    import sbvc_pkg::*;

    // The bitset holds MAX_OBJECTS bits in words of WORD_BITS. Only words that an
    // object_id can reach are built; anything at or past WORDS reads as zero.
    localparam int WORDS     = (MAX_OBJECTS + WORD_BITS - 1) / WORD_BITS;
    localparam int ID_WORDS  = (ID_SPACE + WORD_BITS - 1) / WORD_BITS;
    localparam int MEM_WORDS = (WORDS < ID_WORDS) ? WORDS : ID_WORDS;
    localparam int MEM_AW    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int CNT_W     = $clog2(MAX_OBJECTS + 1);

    // Configuration registers. The radius square is kept in a register of its own;
    // the user must see that configuration only changes while the block is idle (the block
    // does not enforce this), so it is settled long before an item reaches the compare.
    logic signed [COORD_W-1:0]  r_center [3];
    logic        [RADIUS_W-1:0] r_radius;
    logic                       r_shadow_only;
    logic        [R2_W-1:0]     r_r2;

    // Pipeline occupancy and per-stage ready. Each stage takes a new item when it
    // is empty or its contents move on, so bubbles close up under back-pressure.
    logic [N_STG-1:0] r_v;
    logic [N_STG-1:0] rdy;

    t_side                      r_sd [STG_A:STG_F];
    logic signed [COORD_W-1:0]  r_a_lo [3];
    logic signed [COORD_W-1:0]  r_a_hi [3];
    logic        [SQ_W-1:0]     sq [3];
    logic        [SUM_W-1:0]    r_e_sum;
    logic                       r_f_in;
    t_axis_ld                   axis_ld;

    // Bitset access.
    logic [ID_W-1:0]      e_word;
    logic [ID_W-1:0]      f_word_idx;
    logic [BIT_W-1:0]     f_bit;
    logic                 f_in_range;
    logic [WORD_BITS-1:0] f_word;
    logic [WORD_BITS-1:0] f_set;
    logic                 f_fire;

    // Result of the item in stage F.
    t_verdict             f_verdict;
    logic                 f_query;
    logic                 f_wr;
    logic                 f_clr;
    logic                 f_skip;
    logic [CNT_W-1:0]     r_vis_cnt;
    logic [CNT_W-1:0]     r_cul_cnt;
    logic [CNT_W-1:0]     n_vis_cnt;
    logic [CNT_W-1:0]     n_cul_cnt;
    logic [CNT_W-1:0]     vis_inc;
    logic [CNT_W-1:0]     cul_inc;
    logic [CNT_W+COUNT_W-1:0] vis_ext;
    logic [CNT_W+COUNT_W-1:0] cul_ext;

    // Output register.
    t_verdict             r_o_verdict;
    logic                 r_o_query;
    logic [COUNT_W-1:0]   r_o_vis;
    logic [COUNT_W-1:0]   r_o_cul;

    // ------------------------------------------------------------------
    // Configuration. Indexes past the register list are ignored.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center[0]   <= '0;
            r_center[1]   <= '0;
            r_center[2]   <= '0;
            r_radius      <= '0;
            r_shadow_only <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CENTER_X:    r_center[0]   <= i_cfg_data[COORD_W-1:0];
                CFG_CENTER_Y:    r_center[1]   <= i_cfg_data[COORD_W-1:0];
                CFG_CENTER_Z:    r_center[2]   <= i_cfg_data[COORD_W-1:0];
                CFG_RADIUS:      r_radius      <= i_cfg_data[RADIUS_W-1:0];
                CFG_SHADOW_ONLY: r_shadow_only <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_r2 <= R2_W'(r_radius) * R2_W'(r_radius);
    end

    // ------------------------------------------------------------------
    // Handshake chain, from the output back to the input.
    // ------------------------------------------------------------------
    always_comb begin
        rdy[STG_O] = !r_v[STG_O] || m_axis_tready;
        for (int k = STG_F; k >= STG_A; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    assign s_axis_tready = rdy[STG_A];
    assign m_axis_tvalid = r_v[STG_O];
    assign f_fire        = r_v[STG_F] && rdy[STG_O];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[STG_A]) begin
                r_v[STG_A] <= s_axis_tvalid;
            end
            for (int k = STG_B; k <= STG_O; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage A: register the beat. Sideband then walks along with the geometry.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (rdy[STG_A]) begin
            r_sd[STG_A].op           <= s_axis_tuser;
            r_sd[STG_A].id           <= s_axis_tdata[IN_ID_LSB +: ID_W];
            r_sd[STG_A].has_model    <= s_axis_tdata[IN_MODEL_BIT];
            r_sd[STG_A].casts_shadow <= s_axis_tdata[IN_SHADOW_BIT];
            r_sd[STG_A].has_lod      <= s_axis_tdata[IN_LOD_BIT];
            for (int a = 0; a < 3; a++) begin
                r_a_lo[a] <= s_axis_tdata[IN_BOX_LSB + a * COORD_W +: COORD_W];
                r_a_hi[a] <= s_axis_tdata[IN_BOX_LSB + (a + 3) * COORD_W +: COORD_W];
            end
        end
        for (int k = STG_B; k <= STG_F; k++) begin
            if (rdy[k]) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages B to D: per axis clamp, distance and square.
    // ------------------------------------------------------------------
    assign axis_ld.b = rdy[STG_B];
    assign axis_ld.c = rdy[STG_C];
    assign axis_ld.d = rdy[STG_D];

    for (genvar a = 0; a < 3; a++) begin : g_axis
        sbvc_axis u_axis (
            .i_clk    (i_clk),
            .i_ld     (axis_ld),
            .i_center (r_center[a]),
            .i_lo     (r_a_lo[a]),
            .i_hi     (r_a_hi[a]),
            .o_sq     (sq[a])
        );
    end

    // ------------------------------------------------------------------
    // Stage E: exact sum of the three squares. The sum is kept at full width,
    // which gives the same verdict as a saturating sum because the radius square
    // stays far below the saturation point.
    // Stage F: compare against the radius square.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (rdy[STG_E]) begin
            r_e_sum <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
        end
        if (rdy[STG_F]) begin
            r_f_in <= (r_e_sum <= SUM_W'(r_r2));
        end
    end

    // ------------------------------------------------------------------
    // Bitset memory. The word is read as the item enters stage F and written
    // back as it leaves; the memory forwards a write or clear that meets the
    // next item's read at the same edge.
    // ------------------------------------------------------------------
    always_comb begin
        e_word     = ID_W'(r_sd[STG_E].id / WORD_BITS);
        f_word_idx = ID_W'(r_sd[STG_F].id / WORD_BITS);
        f_bit      = BIT_W'(r_sd[STG_F].id % WORD_BITS);
        f_in_range = 32'(f_word_idx) < WORDS;
        f_set      = f_word | ({{(WORD_BITS - 1){1'b0}}, 1'b1} << f_bit);
    end

    sbvc_bitmem #(
        .DEPTH (MEM_WORDS),
        .WIDTH (WORD_BITS),
        .AW    (MEM_AW)
    ) u_bitmem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rdy[STG_F]),
        .i_rd_addr (e_word[MEM_AW-1:0]),
        .i_wr_en   (f_wr && f_fire),
        .i_wr_addr (f_word_idx[MEM_AW-1:0]),
        .i_wr_data (f_set),
        .i_clr     (f_clr && f_fire),
        .o_rd_data (f_word)
    );

    // ------------------------------------------------------------------
    // Verdict, query bit and counters of the item in stage F. Counters are
    // committed as the item leaves, so each result carries the counts after it.
    // ------------------------------------------------------------------
    always_comb begin
        vis_inc   = (r_vis_cnt < CNT_W'(MAX_OBJECTS)) ? r_vis_cnt + 1'b1 : r_vis_cnt;
        cul_inc   = (r_cul_cnt < CNT_W'(MAX_OBJECTS)) ? r_cul_cnt + 1'b1 : r_cul_cnt;
        f_skip    = !r_sd[STG_F].has_model || (r_shadow_only && !r_sd[STG_F].casts_shadow);
        f_verdict = V_SKIP;
        f_query   = 1'b0;
        f_wr      = 1'b0;
        f_clr     = 1'b0;
        n_vis_cnt = r_vis_cnt;
        n_cul_cnt = r_cul_cnt;
        case (r_sd[STG_F].op)
            OP_BEGIN: begin
                f_clr     = 1'b1;
                n_vis_cnt = '0;
                n_cul_cnt = '0;
            end
            OP_TEST: begin
                if (f_skip) begin
                    f_verdict = V_SKIP;
                end else if (!r_sd[STG_F].has_lod) begin
                    f_verdict = V_CULL_LOD;
                    n_cul_cnt = cul_inc;
                end else if (r_f_in) begin
                    f_verdict = V_VISIBLE;
                    f_wr      = f_in_range;
                    n_vis_cnt = vis_inc;
                end else begin
                    f_verdict = V_CULL_OUT;
                    n_cul_cnt = cul_inc;
                end
            end
            OP_QUERY: begin
                f_query = f_in_range && f_word[f_bit];
            end
            default: ;
        endcase
        vis_ext = {{COUNT_W{1'b0}}, n_vis_cnt};
        cul_ext = {{COUNT_W{1'b0}}, n_cul_cnt};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vis_cnt <= '0;
            r_cul_cnt <= '0;
        end else if (f_fire) begin
            r_vis_cnt <= n_vis_cnt;
            r_cul_cnt <= n_cul_cnt;
        end
    end

    // ------------------------------------------------------------------
    // Stage O: output register, held while the downstream side stalls.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (rdy[STG_O]) begin
            r_o_verdict <= f_verdict;
            r_o_query   <= f_query;
            r_o_vis     <= vis_ext[COUNT_W-1:0];
            r_o_cul     <= cul_ext[COUNT_W-1:0];
        end
    end

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, r_o_cul, r_o_vis, r_o_query, r_o_verdict};

endmodule

`default_nettype wire

### design/sbvc_axis.sv
`default_nettype none

module sbvc_axis (
    input  wire logic                                 i_clk,
    input  wire sbvc_pkg::t_axis_ld                   i_ld,
    input  wire logic signed [sbvc_pkg::COORD_W-1:0]  i_center,
    input  wire logic signed [sbvc_pkg::COORD_W-1:0]  i_lo,
    input  wire logic signed [sbvc_pkg::COORD_W-1:0]  i_hi,
    output logic [sbvc_pkg::SQ_W-1:0]                 o_sq
);
    import sbvc_pkg::*;

    logic signed [COORD_W-1:0] lo_clip;
    logic signed [COORD_W-1:0] n_p;
    logic signed [COORD_W-1:0] r_p;
    logic        [COORD_W:0]   diff;
    logic        [COORD_W-1:0] n_d;
    logic        [COORD_W-1:0] r_d;
    logic        [SQ_W-1:0]    n_sq;
    logic        [SQ_W-1:0]    r_sq;

    // Clamp as max then min, so an inverted box lands on its maximum.
    always_comb begin
        lo_clip = (i_center < i_lo) ? i_lo : i_center;
        n_p     = (lo_clip > i_hi) ? i_hi : lo_clip;
        diff    = {r_p[COORD_W-1], r_p} - {i_center[COORD_W-1], i_center};
        n_d     = diff[COORD_W] ? COORD_W'(-diff) : COORD_W'(diff);
        n_sq    = r_d * r_d;
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.b) begin
            r_p <= n_p;
        end
        if (i_ld.c) begin
            r_d <= n_d;
        end
        if (i_ld.d) begin
            r_sq <= n_sq;
        end
    end

    assign o_sq = r_sq;

endmodule

`default_nettype wire

### design/sbvc_bitmem.sv
`default_nettype none

module sbvc_bitmem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64,
    parameter int AW    = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_clr,
    output logic [WIDTH-1:0]      o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_q;
    logic             r_q_vld;
    logic             r_fwd;
    logic [WIDTH-1:0] r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q        <= mem[i_rd_addr];
            r_fwd_data <= i_clr ? '0 : i_wr_data;
        end
    end

    // A clear wipes every word at once through the valid bits. A read that
    // meets a write or clear at the same edge takes the new contents instead.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_q_vld <= 1'b0;
            r_fwd   <= 1'b0;
        end else begin
            if (i_clr) begin
                r_valid <= '0;
            end else if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_q_vld <= r_valid[i_rd_addr];
                r_fwd   <= i_clr || (i_wr_en && (i_wr_addr == i_rd_addr));
            end
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : (r_q_vld ? r_q : '0);

endmodule

`default_nettype wire

### design/sbvc_checker.sv
`default_nettype none

module sbvc_checker #(
    parameter int MAX_OBJECTS = sbvc_pkg::MAX_OBJECTS_DEF
) (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_cfg_we,
    input wire logic [sbvc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input wire logic [sbvc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input wire logic                              s_axis_tvalid,
    input wire logic                              s_axis_tready,
    input wire logic [sbvc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input wire logic [sbvc_pkg::OP_W-1:0]         s_axis_tuser,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [sbvc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import sbvc_pkg::*;

    localparam bit COUNT_FITS = MAX_OBJECTS < (1 << COUNT_W);

    logic [VERDICT_W-1:0] verdict;
    logic                 query;
    logic [COUNT_W-1:0]   vis_count;
    logic [COUNT_W-1:0]   cul_count;

    assign verdict   = m_axis_tdata[OUT_VERDICT_LSB +: VERDICT_W];
    assign query     = m_axis_tdata[OUT_QUERY_BIT];
    assign vis_count = m_axis_tdata[OUT_VIS_LSB +: COUNT_W];
    assign cul_count = m_axis_tdata[OUT_CUL_LSB +: COUNT_W];

    // No result beat is offered in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat offered straight after reset");

    // A stalled result beat stays offered and unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result beat changed");

    // Only a query can report a set bit, and a query carries no verdict.
    a_query_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && query |-> verdict == V_SKIP)
        else $error("query bit set on a tested object");

    // A visible verdict has just been counted, so its count is non-zero.
    a_vis_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && COUNT_FITS && verdict == V_VISIBLE |-> vis_count != '0)
        else $error("visible verdict with zero visible count");

    // Likewise for either kind of cull.
    a_cul_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && COUNT_FITS && (verdict == V_CULL_LOD || verdict == V_CULL_OUT)
        |-> cul_count != '0)
        else $error("culled verdict with zero culled count");

endmodule

bind sphere_box_visibility_cull_unit sbvc_checker #(
    .MAX_OBJECTS (MAX_OBJECTS)
) u_sbvc_checker (.*);

`default_nettype wire

### tb/sphere_box_visibility_cull_unit_tb.sv
`default_nettype none

module sphere_box_visibility_cull_unit_tb;

    import sbvc_pkg::*;

    // The op field has one code that the package leaves unnamed; the block must ignore it.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic [COORD_W-1:0]  COORD_TOP    = 32'h7fff_ffff;
    localparam logic [COORD_W-1:0]  COORD_BOTTOM = 32'h8000_0000;
    localparam logic [RADIUS_W-1:0] RADIUS_TOP   = 31'h7fff_ffff;
    localparam longint COORD_MAX = 64'sd2147483647;
    localparam longint COORD_MIN = -64'sd2147483648;

    localparam int SETTLE_CYCLES  = 12;    // margin for the pipeline to empty
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any beat on either side
    localparam int REPORT_LIMIT   = 100;   // mismatches printed before going quiet

    // One input item. Index 0 of each box corner is the x axis, so the packed
    // arrays drop straight into tdata in field order.
    typedef struct packed {
        logic [OP_W-1:0]                op;
        logic [ID_W-1:0]                id;
        logic                           has_model;
        logic                           casts_shadow;
        logic                           has_lod;
        logic [2:0][COORD_W-1:0]        box_min;
        logic [2:0][COORD_W-1:0]        box_max;
    } cull_item_t;

    typedef struct packed {
        t_verdict                       verdict;
        logic                           query_visible;
        logic [COUNT_W-1:0]             visible_count;
        logic [COUNT_W-1:0]             culled_count;
    } cull_result_t;

    // Ports of the block; the inputs are at known values from time zero.
    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data    = '0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [IN_TDATA_W-1:0]      s_axis_tdata  = '0;
    logic [OP_W-1:0]            s_axis_tuser  = '0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]     m_axis_tdata;

    // Our own copy of the sphere settings, updated as each register is written.
    logic [2:0][COORD_W-1:0]    sphere_centre   = '0;
    logic [RADIUS_W-1:0]        sphere_radius_q = '0;
    logic                       shadow_only     = 1'b0;

    // Our own copy of the pass state.
    bit [ID_SPACE-1:0]          visible_map;
    logic [COUNT_W-1:0]         visible_total   = '0;
    logic [COUNT_W-1:0]         culled_total    = '0;

    cull_item_t                 object_stream[$];    // items still to be offered
    cull_result_t               awaited_verdicts[$]; // results owed by the block
    logic [ID_W-1:0]            tested_ids[$];       // ids tested in the current pass

    cull_item_t                 in_flight   = '0;
    bit                         offered     = 1'b0;
    bit                         drain_hold  = 1'b0;
    bit                         idle_on     = 1'b0;
    int                         gap_left    = 0;
    int                         stall_left  = 0;
    int                         quiet_cycles = 0;
    int                         mismatches  = 0;

    sphere_box_visibility_cull_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // tdata from bit 0: object_id, has_model, casts_shadow, has_lod, box_min_x,
        // box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, zero pad.
        .s_axis_tdata  (s_axis_tdata),
        // tuser: op.
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // tdata from bit 0: verdict, query_visible, visible_count, culled_count, zero pad.
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Squared distance along one axis from the centre to its clamp into [lo, hi].
    // The clamp order matters for inverted boxes: the upper bound wins.
    function automatic logic [SQ_W-1:0] axis_gap_sq(logic signed [COORD_W-1:0] c,
                                                    logic signed [COORD_W-1:0] lo,
                                                    logic signed [COORD_W-1:0] hi);
        logic signed [COORD_W-1:0] p;
        logic signed [COORD_W:0]   d;
        logic [COORD_W:0]          mag;
        p = c;
        if (p < lo) p = lo;
        if (p > hi) p = hi;
        d   = p - c;
        mag = (d < 0) ? -d : d;
        return SQ_W'(mag[COORD_W-1:0]) * SQ_W'(mag[COORD_W-1:0]);
    endfunction

    function automatic logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] n);
        return (n < MAX_OBJECTS_DEF) ? n + 1'b1 : n;
    endfunction

    // Applies one accepted item to the pass state and returns the result it owes.
    function automatic cull_result_t evaluate_item(cull_item_t it);
        cull_result_t r;
        logic [SUM_W-1:0] dist_sq;
        logic [R2_W-1:0]  rad_sq;
        r = '0;
        r.verdict = V_SKIP;
        case (it.op)
            OP_BEGIN: begin
                visible_map   = '0;
                visible_total = '0;
                culled_total  = '0;
            end
            OP_TEST: begin
                if (!it.has_model || (shadow_only && !it.casts_shadow)) begin
                    r.verdict = V_SKIP;
                end else if (!it.has_lod) begin
                    r.verdict    = V_CULL_LOD;
                    culled_total = bump(culled_total);
                end else begin
                    // Exact wide sum, so no saturation is needed to get the verdict.
                    dist_sq = SUM_W'(axis_gap_sq(sphere_centre[0], it.box_min[0], it.box_max[0]))
                            + SUM_W'(axis_gap_sq(sphere_centre[1], it.box_min[1], it.box_max[1]))
                            + SUM_W'(axis_gap_sq(sphere_centre[2], it.box_min[2], it.box_max[2]));
                    rad_sq  = R2_W'(sphere_radius_q) * R2_W'(sphere_radius_q);
                    if (dist_sq <= SUM_W'(rad_sq)) begin
                        r.verdict          = V_VISIBLE;
                        visible_map[it.id] = 1'b1;
                        visible_total      = bump(visible_total);
                    end else begin
                        r.verdict    = V_CULL_OUT;
                        culled_total = bump(culled_total);
                    end
                end
            end
            OP_QUERY: r.query_visible = visible_map[it.id];
            default: ;
        endcase
        r.visible_count = visible_total;
        r.culled_count  = culled_total;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers items from the stream, with bursts of idle cycles and the
    // odd pause until every owed result has come back.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic [IN_TDATA_W-1:0] beat;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                awaited_verdicts.push_back(evaluate_item(in_flight));
                offered = 1'b0;
            end
            if (!offered) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (drain_hold) begin
                    drain_hold = (awaited_verdicts.size() != 0);
                end else if (object_stream.size() != 0) begin
                    if (idle_on && $urandom_range(0, 9) == 0) begin
                        gap_left = $urandom_range(1, 9) - 1;
                    end else if (idle_on && $urandom_range(0, 299) == 0) begin
                        drain_hold = 1'b1;
                    end else begin
                        in_flight = object_stream.pop_front();
                        offered   = 1'b1;
                    end
                end
            end
            beat = '0;
            beat[IN_ID_LSB +: ID_W]  = in_flight.id;
            beat[IN_MODEL_BIT]       = in_flight.has_model;
            beat[IN_SHADOW_BIT]      = in_flight.casts_shadow;
            beat[IN_LOD_BIT]         = in_flight.has_lod;
            beat[IN_BOX_LSB +: 3*COORD_W]             = in_flight.box_min;
            beat[IN_BOX_LSB + 3*COORD_W +: 3*COORD_W] = in_flight.box_max;
            s_axis_tvalid <= offered;
            s_axis_tdata  <= beat;
            s_axis_tuser  <= in_flight.op;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result beat against the oldest owed result and
    // stalls the block's output in random bursts.
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        cull_result_t want;
        logic         ready;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (awaited_verdicts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $error("result beat %h arrived with nothing outstanding", m_axis_tdata);
                end else begin
                    want = awaited_verdicts.pop_front();
                    check_field("verdict", want.verdict,
                                m_axis_tdata[OUT_VERDICT_LSB +: VERDICT_W]);
                    check_field("query_visible", want.query_visible,
                                m_axis_tdata[OUT_QUERY_BIT]);
                    check_field("visible_count", want.visible_count,
                                m_axis_tdata[OUT_VIS_LSB +: COUNT_W]);
                    check_field("culled_count", want.culled_count,
                                m_axis_tdata[OUT_CUL_LSB +: COUNT_W]);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                ready = 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 9) - 1;
                ready      = 1'b0;
            end else begin
                ready = 1'b1;
            end
            m_axis_tready <= ready;
        end
    end

    // Watchdog: any beat on either side restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Roughly uniform pick from [lo, hi].
    function automatic longint pick(longint lo, longint hi);
        longint unsigned span;
        longint unsigned raw;
        span = hi - lo + 1;
        raw  = {$urandom, $urandom};
        return lo + longint'(raw % span);
    endfunction

    function automatic logic [COORD_W-1:0] sat32(longint v);
        if (v > COORD_MAX) return COORD_TOP;
        if (v < COORD_MIN) return COORD_BOTTOM;
        return v[COORD_W-1:0];
    endfunction

    function automatic cull_item_t ctrl_item(logic [OP_W-1:0] op, logic [ID_W-1:0] id);
        cull_item_t it;
        it    = '0;
        it.op = op;
        it.id = id;
        return it;
    endfunction

    // A test of a box whose three axes share the same bounds.
    function automatic cull_item_t cube_item(logic [ID_W-1:0] id, logic [COORD_W-1:0] lo,
                                             logic [COORD_W-1:0] hi);
        cull_item_t it;
        it              = ctrl_item(OP_TEST, id);
        it.has_model    = 1'b1;
        it.casts_shadow = 1'b1;
        it.has_lod      = 1'b1;
        it.box_min      = {3{lo}};
        it.box_max      = {3{hi}};
        return it;
    endfunction

    function automatic cull_item_t noise_item();
        cull_item_t it;
        it.op           = $urandom_range(0, 3);
        it.id           = $urandom_range(0, ID_SPACE - 1);
        it.has_model    = $urandom_range(0, 1);
        it.casts_shadow = $urandom_range(0, 1);
        it.has_lod      = $urandom_range(0, 1);
        for (int a = 0; a < 3; a++) begin
            it.box_min[a] = $urandom;
            it.box_max[a] = $urandom;
        end
        return it;
    endfunction

    // Puts a box somewhere around the sphere so that hits and misses both occur;
    // now and then one axis is inverted.
    function automatic cull_item_t place_near_sphere(cull_item_t it);
        longint spread, mid, half, c;
        logic [COORD_W-1:0] t;
        spread = (sphere_radius_q == 0) ? pick(1, 65536) : longint'(sphere_radius_q);
        for (int a = 0; a < 3; a++) begin
            c    = $signed(sphere_centre[a]);
            mid  = pick(c - spread - spread / 2, c + spread + spread / 2);
            half = pick(0, spread / 2);
            it.box_min[a] = sat32(mid - half);
            it.box_max[a] = sat32(mid + half);
            if ($urandom_range(0, 15) == 0) begin
                t             = it.box_min[a];
                it.box_min[a] = it.box_max[a];
                it.box_max[a] = t;
            end
        end
        return it;
    endfunction

    // A pass made mostly of object tests, with queries mostly aimed at ids already
    // tested, a few pass restarts, unused op codes and raw noise boxes.
    task automatic queue_random_pass(int count);
        cull_item_t it;
        int roll;
        for (int n = 0; n < count; n++) begin
            it   = noise_item();
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                it.op = OP_BEGIN;
                tested_ids.delete();
            end else if (roll < 5) begin
                it.op = OP_UNUSED;
            end else if (roll < 33) begin
                it.op = OP_QUERY;
                if (tested_ids.size() != 0 && $urandom_range(0, 3) != 0)
                    it.id = tested_ids[$urandom_range(0, tested_ids.size() - 1)];
            end else begin
                if (roll >= 41) it = place_near_sphere(it);
                it.op           = OP_TEST;
                it.has_model    = ($urandom_range(0, 9) != 0);
                it.casts_shadow = ($urandom_range(0, 3) != 0);
                it.has_lod      = ($urandom_range(0, 7) != 0);
                tested_ids.push_back(it.id);
            end
            object_stream.push_back(it);
        end
    endtask

    // One unbroken pass long enough to drive both counters into saturation:
    // tests alternate between a box around the centre and a distance-hint cull.
    task automatic queue_full_pass(int count);
        cull_item_t it;
        longint c;
        tested_ids.delete();
        object_stream.push_back(ctrl_item(OP_BEGIN, $urandom_range(0, ID_SPACE - 1)));
        for (int n = 0; n < count; n++) begin
            it = noise_item();
            if (n % 23 == 0) begin
                it.op = OP_QUERY;
                if (tested_ids.size() != 0)
                    it.id = tested_ids[$urandom_range(0, tested_ids.size() - 1)];
            end else begin
                it.op        = OP_TEST;
                it.has_model = 1'b1;
                it.has_lod   = n[0];
                if (it.has_lod) begin
                    for (int a = 0; a < 3; a++) begin
                        c = $signed(sphere_centre[a]);
                        it.box_min[a] = sat32(c - pick(0, 1 << 20));
                        it.box_max[a] = sat32(c + pick(0, 1 << 20));
                    end
                end
                tested_ids.push_back(it.id);
            end
            object_stream.push_back(it);
        end
    endtask

    // Returns once every item has gone in, every result has come out and the
    // pipeline has had time to empty.
    task automatic wait_drained();
        while (object_stream.size() != 0 || offered || awaited_verdicts.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_CENTER_X:    sphere_centre[0] = data;
            CFG_CENTER_Y:    sphere_centre[1] = data;
            CFG_CENTER_Z:    sphere_centre[2] = data;
            CFG_RADIUS:      sphere_radius_q  = data[RADIUS_W-1:0];
            CFG_SHADOW_ONLY: shadow_only      = data[0];
            default: ;
        endcase
    endtask

    // Registers are only touched once the block has gone quiet.
    task automatic set_sphere(logic [2:0][COORD_W-1:0] centre, logic [RADIUS_W-1:0] radius,
                              logic casters);
        wait_drained();
        write_reg(CFG_CENTER_X, centre[0]);
        write_reg(CFG_CENTER_Y, centre[1]);
        write_reg(CFG_CENTER_Z, centre[2]);
        write_reg(CFG_RADIUS, {1'b0, radius});
        write_reg(CFG_SHADOW_ONLY, {31'b0, casters});
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        cull_item_t it;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        idle_on = 1'b1;

        // Directed items against the reset settings: a point sphere at the origin.
        object_stream.push_back(ctrl_item(OP_QUERY, 0));          // nothing set after reset
        object_stream.push_back(cube_item(5, 32'hffff_ffff, 32'd1));
        object_stream.push_back(ctrl_item(OP_QUERY, 5));
        object_stream.push_back(cube_item(ID_SPACE - 1, 32'd0, 32'd0));
        object_stream.push_back(ctrl_item(OP_QUERY, ID_SPACE - 1));
        object_stream.push_back(cube_item(1, 32'd1, 32'd1));       // just outside
        it = cube_item(2, 32'hffff_ffff, 32'd1);
        it.has_model = 1'b0;                                       // no model: skipped
        object_stream.push_back(it);
        it = cube_item(3, 32'hffff_ffff, 32'd1);
        it.has_lod = 1'b0;                                         // hidden by distance hint
        object_stream.push_back(it);
        it = cube_item(6, 32'hffff_ffff, 32'd1);
        it.casts_shadow = 1'b0;                                    // shadow mode is off
        object_stream.push_back(it);
        object_stream.push_back(ctrl_item(OP_UNUSED, 7));
        object_stream.push_back(cube_item(8, 32'd10, 32'hffff_fffb));  // inverted, clamps to -5
        object_stream.push_back(cube_item(9, 32'd5, 32'd0));           // inverted, clamps to 0
        object_stream.push_back(cube_item(10, COORD_BOTTOM, COORD_TOP));
        object_stream.push_back(cube_item(11, COORD_TOP, COORD_TOP));
        object_stream.push_back(cube_item(12, COORD_BOTTOM, COORD_BOTTOM));
        object_stream.push_back(ctrl_item(OP_QUERY, 9));
        object_stream.push_back(ctrl_item(OP_BEGIN, 0));
        object_stream.push_back(ctrl_item(OP_QUERY, 5));
        object_stream.push_back(ctrl_item(OP_QUERY, ID_SPACE - 1));

        // Largest sphere in the most negative corner, shadow casters only. The far
        // corner overflows a 64-bit sum; the radius boundary is hit exactly.
        set_sphere({3{COORD_BOTTOM}}, RADIUS_TOP, 1'b1);
        object_stream.push_back(cube_item(20, COORD_TOP, COORD_TOP));
        object_stream.push_back(cube_item(21, COORD_BOTTOM, COORD_BOTTOM));
        it = cube_item(22, COORD_BOTTOM, COORD_BOTTOM);
        it.casts_shadow = 1'b0;
        object_stream.push_back(it);
        it = cube_item(23, COORD_BOTTOM, COORD_BOTTOM);
        it.box_min[0] = 32'hffff_ffff;                             // distance equals the radius
        it.box_max[0] = 32'hffff_ffff;
        object_stream.push_back(it);
        it.id         = 24;
        it.box_min[0] = 32'd0;                                     // one step further out
        it.box_max[0] = 32'd0;
        object_stream.push_back(it);
        it = cube_item(25, COORD_BOTTOM, COORD_BOTTOM);
        it.has_model = 1'b0;
        object_stream.push_back(it);
        object_stream.push_back(ctrl_item(OP_QUERY, 23));

        // Random passes over a range of sphere settings.
        set_sphere({sat32(pick(-(1 << 20), 1 << 20)), sat32(pick(-(1 << 20), 1 << 20)),
                    sat32(pick(-(1 << 20), 1 << 20))}, pick(1 << 12, 1 << 22), 1'b0);
        queue_random_pass(420);

        set_sphere({$urandom, $urandom, $urandom}, $urandom_range(0, 32'h7fff_ffff), 1'b1);
        queue_random_pass(420);

        // A stretch with no idling on either side, against a point sphere.
        set_sphere({$urandom, $urandom, $urandom}, '0, 1'b0);
        idle_on = 1'b0;
        queue_random_pass(400);

        set_sphere({3{COORD_TOP}}, RADIUS_TOP, $urandom_range(0, 1));
        idle_on = 1'b1;
        queue_random_pass(420);

        // Final stretch: one long pass without idling, both counters saturate.
        set_sphere({sat32(pick(-(1 << 24), 1 << 24)), sat32(pick(-(1 << 24), 1 << 24)),
                    sat32(pick(-(1 << 24), 1 << 24))}, $urandom_range(0, 32'h7fff_ffff), 1'b0);
        idle_on = 1'b0;
        queue_full_pass(8700);

        wait_drained();
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
design/sbvc_pkg.sv
design/sbvc_axis.sv
design/sbvc_bitmem.sv
design/sphere_box_visibility_cull_unit.sv
design/sbvc_checker.sv
tb/sphere_box_visibility_cull_unit_tb.sv
